[design/gjm_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gjm_pkg: shared types and constants
// Character codes, register indexes, reset values and the junction test
// used by the grid junction marker.
// ----------------------------------------------------------------------------
package gjm_pkg;

    // default line buffer depth (cells per row)
    localparam int MAX_COLS_DEF = 1024;

    // field widths fixed by the interface
    localparam int BYTE_W      = 8;
    localparam int COL_COUNT_W = 11;
    localparam int ROW_W       = 16;
    localparam int VCOUNT_W    = 16;
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 1;

    // character codes
    localparam logic [BYTE_W-1:0] WALL_CH  = 8'h58;   // 'X'
    localparam logic [BYTE_W-1:0] SPACE_CH = 8'h20;   // ' '
    localparam logic [BYTE_W-1:0] MARK_CH  = 8'h42;   // 'B'

    // register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_COL_COUNT = 1'b0;
    localparam logic [CFG_INDEX_W-1:0] REG_ROW_COUNT = 1'b1;

    // register reset values
    localparam logic [COL_COUNT_W-1:0] COL_COUNT_RST = 11'd64;
    localparam logic [ROW_W-1:0]       ROW_COUNT_RST = 16'd64;

    // saturation limits
    localparam logic [ROW_W-1:0]    ROW_MAX    = 16'hFFFF;
    localparam logic [VCOUNT_W-1:0] VCOUNT_MAX = 16'hFFFF;

    // minimum number of open neighbours for a junction
    localparam logic [2:0] MIN_OPEN = 3'd2;

    // per-word status from the raster position tracker
    typedef struct packed {
        logic active;     // word lies inside the grid
        logic produce;    // word yields a result (row 1 and below)
        logic row_ge2;    // center row has a row above it
        logic col_gt0;    // left neighbour inside the row
        logic right_ok;   // right neighbour inside the row
    } pos_flags_t;

    // junction test on one center cell and its four open flags
    function automatic logic is_junction(input logic [BYTE_W-1:0] self,
                                         input logic up, input logic right,
                                         input logic down, input logic left);
        logic [2:0] open_cnt;
        logic       result;
        open_cnt = {2'b00, up} + {2'b00, right} + {2'b00, down} + {2'b00, left};
        result   = 1'b1;
        if (self != SPACE_CH)
        begin
            result = 1'b0;
        end
        if (up && down && !left && !right)
        begin
            result = 1'b0;
        end
        if (left && right && !up && !down)
        begin
            result = 1'b0;
        end
        if (open_cnt < MIN_OPEN)
        begin
            result = 1'b0;
        end
        return result;
    endfunction

endpackage
`default_nettype wire

[design/gjm_in_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gjm_in_if: cell word channel
// Valid/ready channel carrying one raw grid cell per word.
// ----------------------------------------------------------------------------
interface gjm_in_if;
    logic                           valid;
    logic                           ready;
    logic [gjm_pkg::BYTE_W-1:0]     cell_byte;
    logic                           frame_start;

    modport source (output valid, output cell_byte, output frame_start, input ready);
    modport sink   (input valid, input cell_byte, input frame_start, output ready);
endinterface
`default_nettype wire

[design/gjm_out_if.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gjm_out_if: result word channel
// Valid/ready channel carrying one finished cell and the running vertex count.
// ----------------------------------------------------------------------------
interface gjm_out_if;
    logic                           valid;
    logic                           ready;
    logic [gjm_pkg::BYTE_W-1:0]     cell_out;
    logic                           marked;
    logic [gjm_pkg::VCOUNT_W-1:0]   vertex_count;

    modport source (output valid, output cell_out, output marked,
                    output vertex_count, input ready);
    modport sink   (input valid, input cell_out, input marked,
                    input vertex_count, output ready);
endinterface
`default_nettype wire

[design/gjm_position.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gjm_position: raster position tracker
// Keeps column and row of the next cell, applies frame start, row wrap and
// the end-of-grid cut, and reports where the accepted word lands.
// ----------------------------------------------------------------------------
module gjm_position #(
    parameter int MAX_COLS = gjm_pkg::MAX_COLS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                advance,
    input  wire logic                                frame_start,
    input  wire logic [gjm_pkg::COL_COUNT_W-1:0]     col_count,
    input  wire logic [gjm_pkg::ROW_W-1:0]           row_count,
    output logic      [$clog2(MAX_COLS)-1:0]         col,
    output logic      [$clog2(MAX_COLS)-1:0]         right_col,
    output gjm_pkg::pos_flags_t                      flags
);
    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int CNT_W  = ($clog2(MAX_COLS + 1) > gjm_pkg::COL_COUNT_W) ?
                            $clog2(MAX_COLS + 1) : gjm_pkg::COL_COUNT_W;

    logic [COL_W-1:0]          col_reg, col_next;
    logic [gjm_pkg::ROW_W-1:0] row_reg, row_next;

    logic [CNT_W-1:0]          cols_eff;
    logic [CNT_W-1:0]          col_count_ext;
    logic [COL_W-1:0]          col0, col1;
    logic [gjm_pkg::ROW_W-1:0] row0, row1;
    logic [CNT_W-1:0]          col_inc;
    logic                      wrap0, wrap1;

    // effective row length: zero acts as one, clamp to buffer depth
    always_comb
    begin
        col_count_ext = CNT_W'(col_count);
        if (col_count_ext == '0)
        begin
            cols_eff = CNT_W'(1);
        end
        else if (col_count_ext > CNT_W'(MAX_COLS))
        begin
            cols_eff = CNT_W'(MAX_COLS);
        end
        else
        begin
            cols_eff = col_count_ext;
        end
    end

    // position of this word and of the one after it
    always_comb
    begin
        col0  = frame_start ? '0 : col_reg;
        row0  = frame_start ? '0 : row_reg;
        wrap0 = CNT_W'(col0) >= cols_eff;
        col1  = wrap0 ? '0 : col0;
        if (wrap0 && row0 != gjm_pkg::ROW_MAX)
        begin
            row1 = row0 + gjm_pkg::ROW_W'(1);
        end
        else
        begin
            row1 = row0;
        end

        col_inc = CNT_W'(col1) + CNT_W'(1);
        wrap1   = col_inc >= cols_eff;

        flags.active   = row1 < row_count;
        flags.produce  = flags.active && (row1 != '0);
        flags.row_ge2  = row1 >= gjm_pkg::ROW_W'(2);
        flags.col_gt0  = col1 != '0;
        flags.right_ok = !wrap1;

        col       = col1;
        right_col = wrap1 ? col1 : col_inc[COL_W-1:0];

        col_next = col1;
        row_next = row1;
        if (flags.active)
        begin
            col_next = wrap1 ? '0 : col_inc[COL_W-1:0];
            if (wrap1 && row1 != gjm_pkg::ROW_MAX)
            begin
                row_next = row1 + gjm_pkg::ROW_W'(1);
            end
        end
    end

    // position registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule
`default_nettype wire

[design/grid_junction_marker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grid_junction_marker: streaming junction marker for a character grid maze
// Marks open interior cells that branch or turn with 'B' and counts them.
// ----------------------------------------------------------------------------
// Cells enter in raster order, one word per clock while the result channel
// keeps up; a stalled sink holds cells.ready low. Each cell of row r+1
// releases the finished byte of the cell above it in row r, registered in
// the evaluation stage and then in the output register; row 0 comes out
// unchanged one row late and the last row is never emitted. The rate is
// set by the byte line buffer, which takes one write and two reads (center
// and right neighbour) per cell, and by the wall-flag buffer with one read
// and one write per cell; a one-deep forward covers a wall flag written on
// the same edge it is read. Both buffers hold undefined data after reset and
// need a frame_start word before use. The output register decouples the
// sink, so a new cell is taken while a result waits. Configuration writes
// must happen while the block is idle.
// ----------------------------------------------------------------------------
module grid_junction_marker #(
    parameter int MAX_COLS = gjm_pkg::MAX_COLS_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    gjm_in_if.sink                                   cells,
    gjm_out_if.source                                results,
    input  wire logic                                wr_en,
    input  wire logic [gjm_pkg::CFG_INDEX_W-1:0]     wr_index,
    input  wire logic [gjm_pkg::CFG_DATA_W-1:0]      wr_data
);
    localparam int COL_W = $clog2(MAX_COLS);

    // configuration
    logic [gjm_pkg::COL_COUNT_W-1:0] col_count_reg;
    logic [gjm_pkg::ROW_W-1:0]       row_count_reg;

    // position tracker outputs
    logic [COL_W-1:0]    pos_col;
    logic [COL_W-1:0]    pos_right_col;
    gjm_pkg::pos_flags_t pos_flags;

    // line buffers
    logic [gjm_pkg::BYTE_W-1:0] byte_mem [MAX_COLS];
    logic                       wall_mem [MAX_COLS];

    // evaluation stage
    logic                       b_valid_reg;
    logic [COL_W-1:0]           b_col_reg;
    logic [gjm_pkg::BYTE_W-1:0] b_byte_reg;
    logic                       b_row_ge2_reg;
    logic                       b_col_gt0_reg;
    logic                       b_right_ok_reg;
    logic [gjm_pkg::BYTE_W-1:0] orig_rd_reg;
    logic [gjm_pkg::BYTE_W-1:0] right_rd_reg;
    logic                       wall_rd_reg;
    logic                       fwd_hit_reg;
    logic                       fwd_wall_reg;

    // per-grid running state
    logic [gjm_pkg::BYTE_W-1:0]   left_reg;
    logic [gjm_pkg::VCOUNT_W-1:0] total_reg, total_next;

    // output register
    logic                         out_valid_reg;
    logic [gjm_pkg::BYTE_W-1:0]   cell_out_reg;
    logic                         marked_reg;
    logic [gjm_pkg::VCOUNT_W-1:0] vcount_reg;

    // handshake
    logic accept;
    logic b_advance;
    logic cfg_write;

    // evaluation signals
    logic up_wall, up_open, left_open, right_open, down_open;
    logic mark;
    logic orig_wall;

    assign cfg_write = wr_en;
    assign b_advance = b_valid_reg && (!out_valid_reg || results.ready);
    assign cells.ready = !b_valid_reg || b_advance;
    assign accept = cells.valid && cells.ready;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_count_reg <= gjm_pkg::COL_COUNT_RST;
            row_count_reg <= gjm_pkg::ROW_COUNT_RST;
        end
        else if (cfg_write)
        begin
            case (wr_index)
                gjm_pkg::REG_COL_COUNT: col_count_reg <= wr_data[gjm_pkg::COL_COUNT_W-1:0];
                gjm_pkg::REG_ROW_COUNT: row_count_reg <= wr_data[gjm_pkg::ROW_W-1:0];
                default: ;
            endcase
        end
    end

    gjm_position #(
        .MAX_COLS (MAX_COLS)
    ) u_position (
        .clk         (clk),
        .rst_n       (rst_n),
        .advance     (accept),
        .frame_start (cells.frame_start),
        .col_count   (col_count_reg),
        .row_count   (row_count_reg),
        .col         (pos_col),
        .right_col   (pos_right_col),
        .flags       (pos_flags)
    );

    // byte line buffer: read center and right, then write the new cell
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            orig_rd_reg  <= byte_mem[pos_col];
            right_rd_reg <= byte_mem[pos_right_col];
            if (pos_flags.active)
            begin
                byte_mem[pos_col] <= cells.cell_byte;
            end
        end
    end

    // wall flag buffer: read at acceptance, written when a result retires
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            wall_rd_reg <= wall_mem[pos_col];
        end
        if (b_advance)
        begin
            wall_mem[b_col_reg] <= orig_wall;
        end
    end

    // evaluation stage payload and same-edge wall forward
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_col_reg      <= pos_col;
            b_byte_reg     <= cells.cell_byte;
            b_row_ge2_reg  <= pos_flags.row_ge2;
            b_col_gt0_reg  <= pos_flags.col_gt0;
            b_right_ok_reg <= pos_flags.right_ok;
            fwd_hit_reg    <= b_advance && (b_col_reg == pos_col);
            fwd_wall_reg   <= orig_wall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            b_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            b_valid_reg <= pos_flags.produce;
        end
        else if (b_advance)
        begin
            b_valid_reg <= 1'b0;
        end
    end

    // junction decision for the center cell
    always_comb
    begin
        orig_wall  = orig_rd_reg == gjm_pkg::WALL_CH;
        up_wall    = fwd_hit_reg ? fwd_wall_reg : wall_rd_reg;
        up_open    = !up_wall;
        left_open  = b_col_gt0_reg && (left_reg != gjm_pkg::WALL_CH);
        right_open = b_right_ok_reg && (right_rd_reg != gjm_pkg::WALL_CH);
        down_open  = b_byte_reg != gjm_pkg::WALL_CH;
        mark       = b_row_ge2_reg &&
                     gjm_pkg::is_junction(orig_rd_reg, up_open, right_open,
                                          down_open, left_open);
        if (mark && total_reg != gjm_pkg::VCOUNT_MAX)
        begin
            total_next = total_reg + gjm_pkg::VCOUNT_W'(1);
        end
        else
        begin
            total_next = total_reg;
        end
    end

    // running left neighbour and vertex total; frame start wins
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            left_reg  <= '0;
            total_reg <= '0;
        end
        else
        begin
            if (b_advance)
            begin
                left_reg  <= orig_rd_reg;
                total_reg <= total_next;
            end
            if (accept && cells.frame_start)
            begin
                left_reg  <= '0;
                total_reg <= '0;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (b_advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (results.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (b_advance)
        begin
            cell_out_reg <= mark ? gjm_pkg::MARK_CH : orig_rd_reg;
            marked_reg   <= mark;
            vcount_reg   <= total_next;
        end
    end

    assign results.valid        = out_valid_reg;
    assign results.cell_out     = cell_out_reg;
    assign results.marked       = marked_reg;
    assign results.vertex_count = vcount_reg;

endmodule
`default_nettype wire

[design/gjm_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// gjm_checker: port-level checks for the grid junction marker
// Watches the cell and result channels and flags protocol or marking slips.
// ----------------------------------------------------------------------------
module gjm_checker (
    input wire logic                              clk,
    input wire logic                              rst_n,
    input wire logic                              in_valid,
    input wire logic                              in_ready,
    input wire logic                              out_valid,
    input wire logic                              out_ready,
    input wire logic [gjm_pkg::BYTE_W-1:0]        cell_out,
    input wire logic                              marked,
    input wire logic [gjm_pkg::VCOUNT_W-1:0]      vertex_count
);

    // a stalled result word stays offered
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
    else $error("result word dropped while stalled");

    // a stalled result word keeps its payload
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> $stable(cell_out) && $stable(marked)
                                    && $stable(vertex_count))
    else $error("result payload changed while stalled");

    // a fresh result traces back to an accepted cell
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
    else $error("result appeared without a preceding cell");

    // a marked cell carries the junction character
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && marked |-> cell_out == gjm_pkg::MARK_CH)
    else $error("marked cell without junction character");

    // a marked cell has been counted
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && marked |-> vertex_count != '0)
    else $error("marked cell with zero vertex count");

endmodule

bind grid_junction_marker gjm_checker u_gjm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (cells.valid),
    .in_ready     (cells.ready),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .cell_out     (results.cell_out),
    .marked       (results.marked),
    .vertex_count (results.vertex_count)
);
`default_nettype wire

[verif/grid_junction_marker_checker.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grid_junction_marker_checker: result predictor and scoreboard
// Watches the cell and result channels and the register write port, keeps
// its own copy of the line buffers, position and vertex count, and compares
// every result word with the oldest predicted word, field by field.
// ----------------------------------------------------------------------------
module grid_junction_marker_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    gjm_in_if                                    cells,
    gjm_out_if                                   results,
    input  wire logic                            wr_en,
    input  wire logic [gjm_pkg::CFG_INDEX_W-1:0] wr_index,
    input  wire logic [gjm_pkg::CFG_DATA_W-1:0]  wr_data,
    output int unsigned                          mismatch_count,
    output int unsigned                          pending_count
);

    localparam int COLS_MAX   = gjm_pkg::MAX_COLS_DEF;
    localparam int REPORT_MAX = 10;

    typedef struct packed {
        logic [gjm_pkg::BYTE_W-1:0]   byte_val;
        logic                         marked;
        logic [gjm_pkg::VCOUNT_W-1:0] vcount;
    } cell_word_t;

    // shadow copy of the block state
    logic                            wall_above [COLS_MAX];
    logic [gjm_pkg::BYTE_W-1:0]      row_bytes  [COLS_MAX];
    logic [gjm_pkg::BYTE_W-1:0]      left_byte;
    int unsigned                     col_pos;
    int unsigned                     row_pos;
    logic [gjm_pkg::VCOUNT_W-1:0]    vtx_total;
    logic [gjm_pkg::COL_COUNT_W-1:0] cols_reg;
    logic [gjm_pkg::ROW_W-1:0]       rows_reg;

    cell_word_t  finished_cells[$];
    int unsigned bad_words;

    // open space that turns or branches
    function automatic logic branches(input logic [gjm_pkg::BYTE_W-1:0] self,
                                      input logic n_up, input logic n_right,
                                      input logic n_down, input logic n_left);
        int open_n;
        open_n = int'(n_up) + int'(n_right) + int'(n_down) + int'(n_left);
        if (self != gjm_pkg::SPACE_CH)
        begin
            return 1'b0;
        end
        if (n_up && n_down && !n_left && !n_right)
        begin
            return 1'b0;
        end
        if (n_left && n_right && !n_up && !n_down)
        begin
            return 1'b0;
        end
        return open_n >= 2;
    endfunction

    // 0 behaves as one column, oversize as the buffer depth
    function automatic int unsigned row_width();
        if (cols_reg == '0)
        begin
            return 1;
        end
        if (cols_reg > COLS_MAX)
        begin
            return COLS_MAX;
        end
        return cols_reg;
    endfunction

    // advance the raster position by one cell and queue the word it releases
    task automatic mark_cell(input logic [gjm_pkg::BYTE_W-1:0] b, input logic fs);
        int unsigned                cols;
        int unsigned                c;
        logic [gjm_pkg::BYTE_W-1:0] orig;
        logic                       hit;
        cell_word_t                 word;
        cols = row_width();
        if (fs)
        begin
            col_pos   = 0;
            row_pos   = 0;
            vtx_total = '0;
            left_byte = '0;
        end
        if (col_pos >= cols)
        begin
            col_pos = 0;
            if (row_pos < gjm_pkg::ROW_MAX)
            begin
                row_pos++;
            end
        end
        // past the last row: nothing changes until the next frame start
        if (row_pos >= rows_reg)
        begin
            return;
        end
        c = col_pos;
        if (row_pos == 0)
        begin
            row_bytes[c] = b;
        end
        else
        begin
            orig = row_bytes[c];
            hit  = 1'b0;
            if (row_pos >= 2)
            begin
                hit = branches(orig, !wall_above[c],
                               (c + 1 < cols) && (row_bytes[c + 1] != gjm_pkg::WALL_CH),
                               b != gjm_pkg::WALL_CH,
                               (c > 0) && (left_byte != gjm_pkg::WALL_CH));
            end
            if (hit && vtx_total != gjm_pkg::VCOUNT_MAX)
            begin
                vtx_total++;
            end
            word.byte_val = hit ? gjm_pkg::MARK_CH : orig;
            word.marked   = hit;
            word.vcount   = vtx_total;
            finished_cells.push_back(word);
            wall_above[c] = (orig == gjm_pkg::WALL_CH);
            left_byte     = orig;
            row_bytes[c]  = b;
        end
        col_pos = c + 1;
        if (col_pos >= cols)
        begin
            col_pos = 0;
            if (row_pos < gjm_pkg::ROW_MAX)
            begin
                row_pos++;
            end
        end
    endtask

    // compare on result words, predict on cell words
    always @(posedge clk or negedge rst_n)
    begin
        cell_word_t got;
        cell_word_t want;
        if (!rst_n)
        begin
            for (int i = 0; i < COLS_MAX; i++)
            begin
                wall_above[i] = 1'b0;
                row_bytes[i]  = '0;
            end
            left_byte = '0;
            col_pos   = 0;
            row_pos   = 0;
            vtx_total = '0;
            cols_reg  = gjm_pkg::COL_COUNT_RST;
            rows_reg  = gjm_pkg::ROW_COUNT_RST;
            bad_words = 0;
            finished_cells.delete();
            mismatch_count <= 0;
            pending_count  <= 0;
        end
        else
        begin
            if (results.valid && results.ready)
            begin
                got = {results.cell_out, results.marked, results.vertex_count};
                if (finished_cells.size() == 0)
                begin
                    bad_words++;
                    if (bad_words <= REPORT_MAX)
                    begin
                        $display("%0t: unexpected result word cell=%h marked=%b count=%0d",
                                 $realtime, got.byte_val, got.marked, got.vcount);
                    end
                end
                else
                begin
                    want = finished_cells.pop_front();
                    if (got.byte_val !== want.byte_val || got.marked !== want.marked ||
                        got.vcount !== want.vcount)
                    begin
                        bad_words++;
                        if (bad_words <= REPORT_MAX)
                        begin
                            $display({"%0t: result word differs: expected cell=%h ",
                                      "marked=%b count=%0d, got cell=%h marked=%b ",
                                      "count=%0d"},
                                     $realtime, want.byte_val, want.marked, want.vcount,
                                     got.byte_val, got.marked, got.vcount);
                        end
                    end
                end
            end
            if (wr_en)
            begin
                case (wr_index)
                    gjm_pkg::REG_COL_COUNT: cols_reg = wr_data[gjm_pkg::COL_COUNT_W-1:0];
                    gjm_pkg::REG_ROW_COUNT: rows_reg = wr_data[gjm_pkg::ROW_W-1:0];
                    default: ;
                endcase
            end
            if (cells.valid && cells.ready)
            begin
                mark_cell(cells.cell_byte, cells.frame_start);
            end
            mismatch_count <= bad_words;
            pending_count  <= finished_cells.size();
        end
    end

endmodule
`default_nettype wire

[verif/grid_junction_marker_tb.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// grid_junction_marker_tb: testbench top for the grid junction marker
// Drives directed grids (corners, turns, branches, rows past the grid end, a
// column count lowered mid-row), an oversize column count, then random maze
// grids under many register settings.
// Sender bursts and receiver stalls are random; the checker scores results.
// ----------------------------------------------------------------------------
module grid_junction_marker_tb;

    localparam int HALF_PERIOD   = 4;
    localparam int RST_CYCLES    = 4;
    localparam int SETTLE_CYCLES = 8;
    localparam int ITEM_TARGET   = 1600;
    localparam int RUN_LIMIT     = 40_000_000;

    typedef enum {SINK_OPEN, SINK_COIN, SINK_QUARTER, SINK_SPARSE} sink_mode_t;

    logic                            clk = 1'b0;
    logic                            rst_n;
    logic                            wr_en;
    logic [gjm_pkg::CFG_INDEX_W-1:0] wr_index;
    logic [gjm_pkg::CFG_DATA_W-1:0]  wr_data;
    int unsigned                     mismatch_count;
    int unsigned                     pending_count;

    gjm_in_if  cells_if();
    gjm_out_if results_if();

    // sender and receiver pacing state
    int          burst_left = 0;
    int          stall_left = 0;
    int unsigned stall_tick = 0;
    sink_mode_t  sink_mode  = SINK_OPEN;

    // grid shape as last programmed
    int unsigned cur_cols;
    int unsigned cur_rows;
    int unsigned sent_items;

    grid_junction_marker i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cells    (cells_if),
        .results  (results_if),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data)
    );

    grid_junction_marker_checker i_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cells          (cells_if),
        .results        (results_if),
        .wr_en          (wr_en),
        .wr_index       (wr_index),
        .wr_data        (wr_data),
        .mismatch_count (mismatch_count),
        .pending_count  (pending_count)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // hard stop
    initial
    begin
        #(RUN_LIMIT);
        $display("Mismatches found");
        $finish;
    end

    // receiver: switches between stall patterns every so often
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            sink_mode  = sink_mode_t'($urandom_range(0, 3));
            stall_left = $urandom_range(16, 160);
        end
        stall_left--;
        stall_tick++;
        case (sink_mode)
            SINK_OPEN:    results_if.ready <= 1'b1;
            SINK_COIN:    results_if.ready <= ($urandom_range(0, 1) == 1);
            SINK_QUARTER: results_if.ready <= (stall_tick % 4 == 0);
            default:      results_if.ready <= ($urandom_range(0, 7) != 0);
        endcase
    end

    // one cell word, with a random gap ahead of each new burst
    task automatic send_cell(input logic [gjm_pkg::BYTE_W-1:0] b, input logic fs);
        int idle;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 48);
            idle = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
            if (idle > 0)
            begin
                @(negedge clk);
                cells_if.valid <= 1'b0;
                repeat (idle - 1) @(negedge clk);
            end
        end
        burst_left--;
        sent_items++;
        @(negedge clk);
        cells_if.valid       <= 1'b1;
        cells_if.cell_byte   <= b;
        cells_if.frame_start <= fs;
        @(posedge clk);
        while (!cells_if.ready)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_pattern(input logic [gjm_pkg::BYTE_W-1:0] pat[$],
                                input logic fs_first);
        foreach (pat[i])
        begin
            send_cell(pat[i], fs_first && (i == 0));
        end
    endtask

    // hold off until every predicted word is out and the pipeline is empty
    task automatic settle();
        @(negedge clk);
        cells_if.valid <= 1'b0;
        while (pending_count != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [gjm_pkg::CFG_INDEX_W-1:0] idx,
                             input logic [gjm_pkg::CFG_DATA_W-1:0] val);
        @(negedge clk);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= val;
        @(negedge clk);
        wr_en    <= 1'b0;
    endtask

    task automatic set_cols(input logic [gjm_pkg::CFG_DATA_W-1:0] val);
        logic [gjm_pkg::COL_COUNT_W-1:0] raw;
        raw = val[gjm_pkg::COL_COUNT_W-1:0];
        write_reg(gjm_pkg::REG_COL_COUNT, val);
        cur_cols = (raw == '0) ? 1 :
                   ((raw > gjm_pkg::MAX_COLS_DEF) ? gjm_pkg::MAX_COLS_DEF : raw);
    endtask

    task automatic configure(input logic [gjm_pkg::CFG_DATA_W-1:0] cols_val,
                             input logic [gjm_pkg::CFG_DATA_W-1:0] rows_val);
        set_cols(cols_val);
        write_reg(gjm_pkg::REG_ROW_COUNT, rows_val);
        cur_rows = rows_val;
    endtask

    // maze-like content with the odd arbitrary byte
    function automatic logic [gjm_pkg::BYTE_W-1:0] rand_cell();
        int unsigned pick;
        pick = $urandom_range(0, 19);
        if (pick < 9)
        begin
            return gjm_pkg::SPACE_CH;
        end
        if (pick < 17)
        begin
            return gjm_pkg::WALL_CH;
        end
        if (pick == 17)
        begin
            return gjm_pkg::MARK_CH;
        end
        return gjm_pkg::BYTE_W'($urandom());
    endfunction

    // one random grid, sometimes cut short, sometimes followed by ignored words
    task automatic send_grid();
        int unsigned rows_in;
        int unsigned total;
        int unsigned n;
        rows_in = (cur_rows > 12) ? $urandom_range(3, 10) : cur_rows;
        total   = rows_in * cur_cols;
        n       = total;
        if (n > 0 && $urandom_range(0, 7) == 0)
        begin
            n = $urandom_range(1, total);
        end
        for (int unsigned i = 0; i < n; i++)
        begin
            send_cell(rand_cell(), i == 0);
        end
        if (total == 0)
        begin
            repeat ($urandom_range(1, 4)) send_cell(rand_cell(), 1'($urandom_range(0, 1)));
        end
        else if (n == total && rows_in == cur_rows)
        begin
            repeat ($urandom_range(0, 3)) send_cell(rand_cell(), 1'b0);
        end
    endtask

    initial
    begin
        logic [gjm_pkg::BYTE_W-1:0]     pat[$];
        logic [gjm_pkg::CFG_DATA_W-1:0] cols_val;
        logic [gjm_pkg::CFG_DATA_W-1:0] rows_val;
        int unsigned                    pick;

        rst_n                = 1'b0;
        wr_en                = 1'b0;
        wr_index             = '0;
        wr_data              = '0;
        cells_if.valid       = 1'b0;
        cells_if.cell_byte   = '0;
        cells_if.frame_start = 1'b0;
        results_if.ready     = 1'b0;
        cur_cols             = gjm_pkg::COL_COUNT_RST;
        cur_rows             = gjm_pkg::ROW_COUNT_RST;
        sent_items           = 0;
        repeat (RST_CYCLES) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // small grid: corner, branch and turn cases, extreme bytes,
        // last row never emitted, one word past the grid end ignored
        configure(3, 4);
        pat = '{gjm_pkg::WALL_CH, gjm_pkg::SPACE_CH, gjm_pkg::WALL_CH,
                gjm_pkg::SPACE_CH, gjm_pkg::SPACE_CH, gjm_pkg::SPACE_CH,
                gjm_pkg::WALL_CH, gjm_pkg::SPACE_CH, 8'hFF,
                8'h00, gjm_pkg::WALL_CH, gjm_pkg::SPACE_CH,
                8'hFF};
        send_pattern(pat, 1'b1);
        settle();

        // column count lowered while the position sits past it
        configure(4, 4);
        pat = '{gjm_pkg::SPACE_CH, gjm_pkg::SPACE_CH, gjm_pkg::WALL_CH, gjm_pkg::SPACE_CH,
                gjm_pkg::SPACE_CH, gjm_pkg::WALL_CH, gjm_pkg::SPACE_CH};
        send_pattern(pat, 1'b1);
        settle();
        set_cols(3);
        pat = '{gjm_pkg::SPACE_CH, gjm_pkg::SPACE_CH, gjm_pkg::SPACE_CH};
        send_pattern(pat, 1'b0);
        settle();

        // every data bit set: column count beyond the buffer depth
        configure('1, 3);
        for (int i = 0; i < gjm_pkg::MAX_COLS_DEF + 40; i++)
        begin
            send_cell(rand_cell(), i == 0);
        end
        settle();

        // random grids under varied shapes
        while (sent_items < ITEM_TARGET)
        begin
            pick = $urandom_range(0, 9);
            if (pick < 4)
            begin
                cols_val = gjm_pkg::CFG_DATA_W'(pick);
            end
            else if (pick < 8)
            begin
                cols_val = gjm_pkg::CFG_DATA_W'($urandom_range(4, 12));
            end
            else
            begin
                cols_val = gjm_pkg::CFG_DATA_W'($urandom_range(13, 40));
            end
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                rows_val = gjm_pkg::CFG_DATA_W'($urandom_range(0, 2));
            end
            else if (pick == 1)
            begin
                rows_val = gjm_pkg::ROW_MAX;
            end
            else
            begin
                rows_val = gjm_pkg::CFG_DATA_W'($urandom_range(3, 10));
            end
            configure(cols_val, rows_val);
            repeat ($urandom_range(1, 4)) send_grid();
            settle();
        end

        settle();
        if (mismatch_count == 0 && pending_count == 0)
        begin
            $display("No mismatches found");
        end
        else
        begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule
`default_nettype wire
